// ===== design/entropy_sample_qualifier_pools_defines.svh =====
// ----------------------------------------------------------------------------
// Entropy sample qualifier assertion macros
// Concurrent assertion wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ENTROPY_SAMPLE_QUALIFIER_POOLS_DEFINES_SVH
`define ENTROPY_SAMPLE_QUALIFIER_POOLS_DEFINES_SVH
`ifndef SYNTHESIS
`define ESQP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("esqp assertion failed");
`define ESQP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("esqp assertion failed");
`else
`define ESQP_ASSERT(lbl, clk, rstn, prop)
`define ESQP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/esqp_pkg.sv =====
// ----------------------------------------------------------------------------
// Entropy sample qualifier package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package esqp_pkg;

  localparam int NUM_SOURCES_DEF = 16;
  localparam int DERIV_ORDER_DEF = 16;
  localparam int POOL_COUNT_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int MIN_DIFF        = 2;
  localparam int THRESHOLD_RESET = 256;

  localparam int SRC_W      = 4;
  localparam int SMP_W      = 32;
  localparam int BYTES_W    = 16;
  localparam int THR_W      = 16;
  localparam int CREDIT_W   = 32;
  localparam int POOL_W     = 5;
  localparam int FOLD_W     = 6;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CREDIT = 1'b1;

  // register index = paddr[msb]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic tok;
    logic low;
  } link_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic adv;
  } route_ctl_t;

  // 1 + trailing ones of the old counter == 1 + trailing zeros of counter + 1, capped at pools
  function automatic logic [FOLD_W-1:0] fold_count(input logic [CREDIT_W-1:0] cnt,
                                                   input int pools);
    int n;
    n = pools;
    for (int i = CREDIT_W - 1; i >= 1; i--) begin
      if (i < pools && !cnt[i-1]) begin
        n = i;
      end
    end
    return FOLD_W'(n);
  endfunction

endpackage

// ===== design/esqp_cell.sv =====
// ----------------------------------------------------------------------------
// Difference cell
// Holds one difference stage's history for every source; takes the value
// from its left neighbor, stores it and passes on the absolute difference.
// ----------------------------------------------------------------------------
module esqp_cell #(
  parameter int NUM_SOURCES = esqp_pkg::NUM_SOURCES_DEF,
  parameter int VAL_W       = esqp_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic                 hist_valid,
  input  esqp_pkg::link_t      link_in,
  input  logic [VAL_W-1:0]     val_in,
  output esqp_pkg::link_t      link_out,
  output logic [VAL_W-1:0]     val_out
);
  import esqp_pkg::*;

  logic [VAL_W-1:0] mem [NUM_SOURCES];
  logic [VAL_W-1:0] hist_r;
  logic [VAL_W-1:0] hist;
  logic [VAL_W-1:0] diff;
  logic [VAL_W-1:0] val_r;
  logic             tok_r;
  logic             low_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hist_r <= mem[rd_idx];
    end
    if (link_in.tok) begin
      mem[wr_idx] <= val_in;
    end
  end

  always_comb begin
    hist = hist_valid ? hist_r : '0;
    diff = (val_in >= hist) ? (val_in - hist) : (hist - val_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.tok) begin
      val_r <= diff;
      low_r <= link_in.low | (diff < VAL_W'(MIN_DIFF));
    end
  end

  assign link_out.tok = tok_r;
  assign link_out.low = low_r;
  assign val_out      = val_r;

endmodule

// ===== design/esqp_router.sv =====
// ----------------------------------------------------------------------------
// Pool router
// Per-source round-robin pool pointer and per-source row valid bits.
// ----------------------------------------------------------------------------
module esqp_router #(
  parameter int NUM_SOURCES = esqp_pkg::NUM_SOURCES_DEF,
  parameter int POOL_COUNT  = esqp_pkg::POOL_COUNT_DEF,
  parameter int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1,
  parameter int PIDX_W      = $clog2(POOL_COUNT)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  esqp_pkg::route_ctl_t    ctl,
  input  logic [IDX_W-1:0]        rd_idx,
  input  logic [IDX_W-1:0]        wr_idx,
  output logic                    hist_valid,
  output logic [PIDX_W-1:0]       pool
);
  import esqp_pkg::*;

  logic [PIDX_W-1:0]      np_mem [NUM_SOURCES];
  logic [PIDX_W-1:0]      np_r;
  logic [PIDX_W-1:0]      np_wr;
  logic [NUM_SOURCES-1:0] valid_r;
  logic                   hv_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      np_r <= np_mem[rd_idx];
    end
    if (ctl.wr_en) begin
      np_mem[wr_idx] <= np_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hv_r    <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        hv_r <= valid_r[rd_idx];
      end
      if (ctl.wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    pool = hv_r ? np_r : '0;
    if (!ctl.adv) begin
      np_wr = pool;
    end else if (pool == PIDX_W'(POOL_COUNT - 1)) begin
      np_wr = '0;
    end else begin
      np_wr = pool + 1'b1;
    end
  end

  assign hist_valid = hv_r;

endmodule

// ===== design/entropy_sample_qualifier_pools.sv =====
// ----------------------------------------------------------------------------
// Entropy sample qualifier and pool router (top level)
// A sample item is registered and its token walks the cell chain (one cell per
// cycle) into the check state; credit and bad-source items go straight to that state,
// which writes out_tdata once the output is free. New items are taken only when idle.
// Reset: synchronous; clears row valid bits (history and pool pointers read 0),
// credit, reseed counter and seeded flag; threshold returns to 256.
// ----------------------------------------------------------------------------
`include "entropy_sample_qualifier_pools_defines.svh"

module entropy_sample_qualifier_pools #(
  parameter int NUM_SOURCES = esqp_pkg::NUM_SOURCES_DEF,
  parameter int DERIV_ORDER = esqp_pkg::DERIV_ORDER_DEF,
  parameter int POOL_COUNT  = esqp_pkg::POOL_COUNT_DEF,
  parameter int SAMPLE_BITS = esqp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // source[3:0], sample[35:4], byte_count[51:36], zero[55:52]
  input  logic [esqp_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bad_source[0], accepted[1], pool_index[6:2], sample_out[38:7],
  // reseed_now[39], pools_to_fold[45:40], mix_old_key[46], seeded[47]
  output logic [esqp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [esqp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [esqp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [esqp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import esqp_pkg::*;

  localparam int IDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PIDX_W = $clog2(POOL_COUNT);
  localparam int VAL_W  = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam int SRCX_W = SRC_W + 3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CREDIT_W-1:0]   credit_r, credit_nxt;
  logic [CREDIT_W-1:0]   cnt_r, cnt_nxt;
  logic                  seeded_r, seeded_nxt;
  logic [THR_W-1:0]      thr_r;
  logic                  start_r;
  logic [IDX_W-1:0]      idx_r;
  logic [VAL_W-1:0]      smp_r;
  logic                  last_r;
  logic                  check_r;
  logic                  bad_r;
  logic                  acc_r;
  logic [PIDX_W-1:0]     pool_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                  in_fire;
  logic                  in_op;
  logic [SRC_W-1:0]      in_src;
  logic [SMP_W-1:0]      in_smp;
  logic [BYTES_W-1:0]    in_bytes;
  logic [SRCX_W-1:0]     src_ext;
  logic                  src_bad;
  logic [IDX_W-1:0]      in_idx;

  link_t                 links [DERIV_ORDER+1];
  logic [VAL_W-1:0]      vals  [DERIV_ORDER+1];
  logic [DERIV_ORDER:0]  tok_vec;
  logic                  done;
  logic                  adv;
  route_ctl_t            rt_ctl;
  logic                  hist_valid;
  logic [PIDX_W-1:0]     pool;

  logic [CREDIT_W-1:0]   addend;
  logic [CREDIT_W:0]     credit_sum;
  logic [CREDIT_W-1:0]   credit_add;
  logic                  out_write;
  logic                  reseed;
  logic [FOLD_W-1:0]     fold;
  logic                  cfg_wr;

  // input unpack
  assign in_fire  = in_tvalid & in_tready;
  assign in_op    = in_tuser;
  assign in_src   = in_tdata[SRC_W-1:0];
  assign in_smp   = in_tdata[SRC_W+SMP_W-1:SRC_W];
  assign in_bytes = in_tdata[SRC_W+SMP_W+BYTES_W-1:SRC_W+SMP_W];
  assign src_ext  = SRCX_W'(in_src);
  assign src_bad  = (src_ext >= SRCX_W'(NUM_SOURCES));
  assign in_idx   = src_ext[IDX_W-1:0];
  assign in_tready = (state_r == ST_IDLE);

  // cell chain
  assign links[0].tok = start_r;
  assign links[0].low = 1'b0;
  assign vals[0]      = smp_r;

  for (genvar g = 0; g < DERIV_ORDER; g++) begin : g_cell
    esqp_cell #(
      .NUM_SOURCES (NUM_SOURCES),
      .VAL_W       (VAL_W),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .rd_en      (in_fire),
      .rd_idx     (in_idx),
      .wr_idx     (idx_r),
      .hist_valid (hist_valid),
      .link_in    (links[g]),
      .val_in     (vals[g]),
      .link_out   (links[g+1]),
      .val_out    (vals[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= DERIV_ORDER; i++) begin
      tok_vec[i] = links[i].tok;
    end
  end

  assign done = links[DERIV_ORDER].tok;
  assign adv  = ~links[DERIV_ORDER].low;

  assign rt_ctl.rd_en = in_fire;
  assign rt_ctl.wr_en = done;
  assign rt_ctl.adv   = adv;

  esqp_router #(
    .NUM_SOURCES (NUM_SOURCES),
    .POOL_COUNT  (POOL_COUNT),
    .IDX_W       (IDX_W),
    .PIDX_W      (PIDX_W)
  ) u_router (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (rt_ctl),
    .rd_idx     (in_idx),
    .wr_idx     (idx_r),
    .hist_valid (hist_valid),
    .pool       (pool)
  );

  // saturating credit add
  always_comb begin
    if (state_r == ST_RUN) begin
      addend = (adv && pool == '0) ? CREDIT_W'(1) : '0;
    end else begin
      addend = CREDIT_W'({in_bytes, 3'b000});
    end
    credit_sum = {1'b0, credit_r} + {1'b0, addend};
    credit_add = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
  end

  assign out_write = (state_r == ST_CHK) && (!out_tvalid_r || out_tready);
  assign reseed    = check_r && (credit_r >= CREDIT_W'(thr_r));
  assign fold      = fold_count(cnt_r, POOL_COUNT);

  always_comb begin
    state_nxt  = state_r;
    credit_nxt = credit_r;
    cnt_nxt    = cnt_r;
    seeded_nxt = seeded_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_CREDIT) begin
            credit_nxt = credit_add;
            state_nxt  = ST_CHK;
          end else if (src_bad) begin
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (done) begin
          credit_nxt = credit_add;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (out_write) begin
          state_nxt = ST_IDLE;
          if (reseed) begin
            credit_nxt = '0;
            cnt_nxt    = cnt_r + 1'b1;
            seeded_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      credit_r     <= '0;
      cnt_r        <= '0;
      seeded_r     <= 1'b0;
      start_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      credit_r <= credit_nxt;
      cnt_r    <= cnt_nxt;
      seeded_r <= seeded_nxt;
      start_r  <= in_fire && (in_op == OP_SAMPLE) && !src_bad;
      if (out_write) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r   <= in_idx;
      smp_r   <= in_smp[VAL_W-1:0];
      last_r  <= in_tlast;
      bad_r   <= (in_op == OP_SAMPLE) && src_bad;
      acc_r   <= 1'b0;
      pool_r  <= '0;
      check_r <= (in_op == OP_CREDIT);
    end
    if (done) begin
      acc_r   <= adv;
      pool_r  <= adv ? pool : '0;
      check_r <= last_r;
    end
    if (out_write) begin
      out_tdata_r <= {seeded_r | reseed,
                      reseed & seeded_r,
                      reseed ? fold : FOLD_W'(0),
                      reseed,
                      acc_r ? SMP_W'(smp_r) : SMP_W'(0),
                      POOL_W'(pool_r),
                      acc_r,
                      bad_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // configuration port
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(THRESHOLD_RESET);
    end else if (cfg_wr && cfg_pready && cfg_paddr[CFG_ADDR_W-1] == REG_THRESHOLD) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_THRESHOLD) ? CFG_DATA_W'(thr_r) : '0;

  `ESQP_ASSERT(a_chain_one_token, clk, rst_n, $onehot0(tok_vec))
  `ESQP_ASSERT(a_chain_latency, clk, rst_n, start_r |-> ##DERIV_ORDER done)
  `ESQP_ASSERT_NEXT(a_reseed_clears, clk, rst_n, out_write && reseed, credit_r == '0 && seeded_r)
  `ESQP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, state_r != ST_IDLE)

endmodule
